>>> src/bjt_pkg.sv
package bjt_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] nest_type;
   typedef logic [1:0] mode_type;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam mode_type MODE_TOP  = 2'd0;
   localparam mode_type MODE_INT  = 2'd1;
   localparam mode_type MODE_LEN  = 2'd2;
   localparam mode_type MODE_BODY = 2'd3;

   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_MINUS = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   localparam nest_type NS_TOP    = 3'd0;
   localparam nest_type NS_DFIRST = 3'd1;
   localparam nest_type NS_DVAL   = 3'd2;
   localparam nest_type NS_DNEXT  = 3'd3;
   localparam nest_type NS_LFIRST = 3'd4;
   localparam nest_type NS_LNEXT  = 3'd5;

   localparam byte_type CH_LF     = 8'h0a;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_COMMA  = 8'h2c;
   localparam byte_type CH_MINUS  = 8'h2d;
   localparam byte_type CH_ZERO   = 8'h30;
   localparam byte_type CH_NINE   = 8'h39;
   localparam byte_type CH_COLON  = 8'h3a;
   localparam byte_type CH_LBRACK = 8'h5b;
   localparam byte_type CH_BSLASH = 8'h5c;
   localparam byte_type CH_RBRACK = 8'h5d;
   localparam byte_type CH_D      = 8'h64;
   localparam byte_type CH_E      = 8'h65;
   localparam byte_type CH_I      = 8'h69;
   localparam byte_type CH_L      = 8'h6c;
   localparam byte_type CH_LBRACE = 8'h7b;
   localparam byte_type CH_RBRACE = 8'h7d;

   localparam int MAX_RESULTS = 3;

endpackage

>>> src/bjt_req_if.sv
interface bjt_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink (input valid, input op, input data_byte, output ready);
endinterface

>>> src/bjt_rsp_if.sv
interface bjt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        parse_error;
   logic [31:0] error_position;
   logic        last;

   modport source (output valid, output out_byte, output byte_valid, output parse_error,
                   output error_position, output last, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input parse_error,
                 input error_position, input last, output ready);
endinterface

>>> src/bjt_ram.sv
module bjt_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> src/bencode_to_json_transcoder.sv
// channel   dir  payload                                              handshake
// req_chan  in   op, data_byte                                        valid/ready
// rsp_chan  out  out_byte, byte_valid, parse_error, error_position,   valid/ready
//                last
//
// a word is taken into the input register, then processed combinationally
// into a result buffer of up to three words, which drains one word per cycle
// while rsp_chan is ready; the result buffer drain sets the rate of input words
// the next input is processed in the cycle the last buffered result is taken
// synchronous reset clears control state; the nesting memory is not cleared,
// the current nesting level lives in a register and lower levels are written before use
// a stall on rsp_chan holds the buffer; req_chan then fills the input register and stops
module bencode_to_json_transcoder #(
   parameter int STACK_DEPTH = 1024,
   parameter int LENGTH_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   bjt_req_if.sink   req_chan,
   bjt_rsp_if.source rsp_chan
);
   import bjt_pkg::*;

   localparam int SP_W = $clog2(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);

   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff;
   byte_type               in_byte_ff;
   mode_type               mode_ff, mode_in;
   logic [1:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   nest_type               top_ff, top_in;
   logic [31:0]            pos_ff, pos_in;
   logic                   latched_ff, latched_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic                   err_ff, err_in;
   logic [31:0]            epos_ff, epos_in;
   byte_type               bytes_ff [MAX_RESULTS];
   byte_type               bytes_in [MAX_RESULTS];
   logic                   coll_ff;
   nest_type               wdata_ff;

   logic                   proc;
   logic                   push;
   nest_type               wcode;
   nest_type               rd_code;
   nest_type               below;
   logic [SP_W-1:0]        raddr;
   logic [1:0]             n;
   byte_type               rb [MAX_RESULTS];
   logic                   err;
   logic                   is_digit;
   byte_type               c;
   logic                   sep_emit;
   byte_type               sep_ch;
   nest_type               sep_top;
   logic [LENGTH_BITS+3:0] prod;
   logic [LENGTH_BITS-1:0] rem_dec;

   assign c        = in_byte_ff;
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign proc     = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_chan.ready));
   assign below    = coll_ff ? wdata_ff : rd_code;
   assign raddr    = sp_in - SP_W'(1);
   assign rem_dec  = rem_ff - LENGTH_BITS'(1);
   assign prod     = ({4'd0, rem_ff} << 3) + ({4'd0, rem_ff} << 1)
                     + (LENGTH_BITS+4)'(c - CH_ZERO);

   assign req_chan.ready = !in_valid_ff || proc;

   bjt_ram #(
      .WIDTH ($bits(nest_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (push),
      .waddr (sp_ff),
      .wdata (wcode),
      .raddr (raddr),
      .rdata (rd_code)
   );

   // separator ahead of a new value
   always_comb begin
      sep_emit = 1'b0;
      sep_ch   = CH_COMMA;
      sep_top  = top_ff;
      unique case (top_ff)
         NS_DFIRST: sep_top = NS_DVAL;
         NS_DVAL: begin
            sep_emit = 1'b1;
            sep_ch   = CH_COLON;
            sep_top  = NS_DNEXT;
         end
         NS_DNEXT: begin
            sep_emit = 1'b1;
            sep_top  = NS_DVAL;
         end
         NS_LFIRST: sep_top = NS_LNEXT;
         NS_LNEXT:  sep_emit = 1'b1;
         default:   sep_top = top_ff;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      sp_in      = sp_ff;
      top_in     = top_ff;
      pos_in     = pos_ff;
      latched_in = latched_ff;
      push       = 1'b0;
      wcode      = sep_top;
      n          = 2'd0;
      err        = 1'b0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         rb[k] = '0;
      end
      if (proc && !latched_ff) begin
         pos_in = pos_ff + 32'd1;
         if (in_op_ff == OP_END) begin
            if (mode_ff != MODE_TOP || sp_ff != '0) begin
               err = 1'b1;
            end else begin
               rb[0]    = CH_LF;
               n        = 2'd1;
               mode_in  = MODE_TOP;
               phase_in = PHASE_NONE;
               rem_in   = '0;
               sp_in    = '0;
               top_in   = NS_TOP;
               pos_in   = '0;
            end
         end else begin
            unique case (mode_ff)
               MODE_INT: begin
                  if (is_digit) begin
                     phase_in = PHASE_DIGIT;
                     rb[0]    = c;
                     n        = 2'd1;
                  end else if (c == CH_E && phase_ff == PHASE_DIGIT) begin
                     mode_in = MODE_TOP;
                  end else if (c == CH_MINUS && phase_ff == PHASE_NONE) begin
                     phase_in = PHASE_MINUS;
                     rb[0]    = c;
                     n        = 2'd1;
                  end else begin
                     err = 1'b1;
                  end
               end
               MODE_LEN: begin
                  if (is_digit) begin
                     if (|prod[LENGTH_BITS+3:LENGTH_BITS]) begin
                        err = 1'b1;
                     end else begin
                        rem_in = prod[LENGTH_BITS-1:0];
                     end
                  end else if (c == CH_COLON) begin
                     if (rem_ff == '0) begin
                        rb[0]   = CH_QUOTE;
                        n       = 2'd1;
                        mode_in = MODE_TOP;
                     end else begin
                        mode_in = MODE_BODY;
                     end
                  end else begin
                     err = 1'b1;
                  end
               end
               MODE_BODY: begin
                  if (c == CH_QUOTE || c == CH_BSLASH) begin
                     rb[n] = CH_BSLASH;
                     n     = n + 2'd1;
                  end
                  rb[n]  = c;
                  n      = n + 2'd1;
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     rb[n]   = CH_QUOTE;
                     n       = n + 2'd1;
                     mode_in = MODE_TOP;
                  end
               end
               default: begin
                  if (c == CH_D || c == CH_L) begin
                     if (sp_ff == SP_MAX) begin
                        err = 1'b1;
                     end else begin
                        if (sep_emit) begin
                           rb[n] = sep_ch;
                           n     = n + 2'd1;
                        end
                        rb[n]  = (c == CH_D) ? CH_LBRACE : CH_LBRACK;
                        n      = n + 2'd1;
                        push   = 1'b1;
                        sp_in  = sp_ff + SP_W'(1);
                        top_in = (c == CH_D) ? NS_DFIRST : NS_LFIRST;
                     end
                  end else if (c == CH_I) begin
                     if (sep_emit) begin
                        rb[n] = sep_ch;
                        n     = n + 2'd1;
                     end
                     top_in   = sep_top;
                     mode_in  = MODE_INT;
                     phase_in = PHASE_NONE;
                  end else if (is_digit) begin
                     if (sep_emit) begin
                        rb[n] = sep_ch;
                        n     = n + 2'd1;
                     end
                     rb[n]   = CH_QUOTE;
                     n       = n + 2'd1;
                     top_in  = sep_top;
                     rem_in  = LENGTH_BITS'(c - CH_ZERO);
                     mode_in = MODE_LEN;
                  end else if (c == CH_E) begin
                     if (top_ff == NS_LFIRST || top_ff == NS_LNEXT) begin
                        rb[0]  = CH_RBRACK;
                        n      = 2'd1;
                        sp_in  = sp_ff - SP_W'(1);
                        top_in = below;
                     end else if (top_ff == NS_DFIRST || top_ff == NS_DNEXT) begin
                        rb[0]  = CH_RBRACE;
                        n      = 2'd1;
                        sp_in  = sp_ff - SP_W'(1);
                        top_in = below;
                     end else begin
                        err = 1'b1;
                     end
                  end else if (c != CH_LF) begin
                     err = 1'b1;
                  end
               end
            endcase
         end
         if (err) begin
            mode_in    = mode_ff;
            phase_in   = phase_ff;
            rem_in     = rem_ff;
            sp_in      = sp_ff;
            top_in     = top_ff;
            push       = 1'b0;
            latched_in = 1'b1;
            n          = 2'd1;
         end
      end
   end

   // result buffer and input register
   always_comb begin
      in_valid_in = in_valid_ff;
      cnt_in      = cnt_ff;
      err_in      = err_ff;
      epos_in     = epos_ff;
      bytes_in    = bytes_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
      if (proc) begin
         cnt_in   = n;
         err_in   = err;
         epos_in  = pos_ff + 32'd1;
         bytes_in = rb;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         cnt_in      = cnt_ff - 2'd1;
         bytes_in[0] = bytes_ff[1];
         bytes_in[1] = bytes_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_TOP;
         phase_ff    <= PHASE_NONE;
         rem_ff      <= '0;
         sp_ff       <= '0;
         top_ff      <= NS_TOP;
         pos_ff      <= '0;
         latched_ff  <= 1'b0;
         cnt_ff      <= 2'd0;
         err_ff      <= 1'b0;
         coll_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         rem_ff      <= rem_in;
         sp_ff       <= sp_in;
         top_ff      <= top_in;
         pos_ff      <= pos_in;
         latched_ff  <= latched_in;
         cnt_ff      <= cnt_in;
         err_ff      <= err_in;
         coll_ff     <= push && (sp_ff == raddr);
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff   <= req_chan.op;
         in_byte_ff <= req_chan.data_byte;
      end
      epos_ff  <= epos_in;
      bytes_ff <= bytes_in;
      wdata_ff <= wcode;
   end

   assign rsp_chan.valid          = cnt_ff != 2'd0;
   assign rsp_chan.out_byte       = err_ff ? 8'd0 : bytes_ff[0];
   assign rsp_chan.byte_valid     = !err_ff;
   assign rsp_chan.parse_error    = err_ff;
   assign rsp_chan.error_position = err_ff ? epos_ff : 32'd0;
   assign rsp_chan.last           = cnt_ff == 2'd1;

   // an error word always stands alone
   a_err_single : assert property (@(posedge clock) disable iff (reset)
      (err_ff && cnt_ff != 2'd0) |-> (cnt_ff == 2'd1))
      else $error("error result shares the buffer");

   // nothing comes out once an error has been reported
   a_latched_silent : assert property (@(posedge clock) disable iff (reset)
      (proc && latched_ff) |=> (cnt_ff == 2'd0))
      else $error("result after latched error");

   // never push past the deepest nesting level
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (sp_ff != SP_MAX))
      else $error("nesting push beyond depth");

   // a string body always has bytes left
   a_body_len : assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_BODY) |-> (rem_ff != '0))
      else $error("string body with zero length left");

   // a closing bracket only leaves the nesting level it closed
   a_pop_level : assert property (@(posedge clock) disable iff (reset)
      (proc && !err && (sp_in != sp_ff) && !push && (sp_in != '0 || sp_ff != '0)
         && in_op_ff == OP_DATA) |=> (sp_ff == $past(sp_ff) - SP_W'(1)))
      else $error("nesting level moved by more than one");

endmodule

>>> tb/tb_bencode_to_json_transcoder.sv
module tb_bencode_to_json_transcoder;
   import bjt_pkg::*;

   localparam int NEST_DEPTH = 1024;
   localparam int LEN_BITS = 32;
   localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_BITS) - 64'd1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_GAP = 12;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        parse_error;
      logic [31:0] error_position;
      logic        last;
   } json_word_type;

   typedef enum int {
      BAD_STRAY_BYTE,
      BAD_CLOSE_AT_TOP,
      BAD_EMPTY_INT,
      BAD_DOUBLE_MINUS,
      BAD_LENGTH_BYTE,
      BAD_LENGTH_OVERFLOW,
      BAD_END_IN_BODY,
      BAD_END_IN_INT,
      BAD_END_IN_LENGTH,
      BAD_END_OPEN,
      BAD_CLOSE_DICT_VALUE,
      BAD_NEST_OVERFLOW,
      BAD_KINDS
   } bad_stream_type;

   logic clock = 1'b0;
   logic reset;

   bjt_req_if req_chan ();
   bjt_rsp_if rsp_chan ();

   bencode_to_json_transcoder #(
      .STACK_DEPTH(NEST_DEPTH),
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #2 clock = ~clock;

   // parser shadow state
   logic [1:0]  stream_mode;
   logic [1:0]  int_state;
   logic [63:0] str_left;
   nest_type    nest_mem [NEST_DEPTH];
   int unsigned nest_level;
   logic [31:0] stream_pos;
   bit          err_latched;

   json_word_type step_words [$];
   json_word_type expected_json [$];
   json_word_type seen_word;
   json_word_type due_word;

   byte_type    bencode_text [$];

   int sender_idle_pct;
   int rsp_stall_pct;
   int hold_off;
   int cycles = 0;
   int mismatches = 0;
   int items_sent;
   int streams_sent;
   int words_checked = 0;
   string bad_case_text;

   function automatic bit is_digit(byte_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void put_char(byte_type ch);
      step_words.push_back('{out_byte: ch, byte_valid: 1'b1, parse_error: 1'b0,
                             error_position: 32'd0, last: 1'b0});
   endfunction

   function automatic void clear_parser();
      stream_mode = MODE_TOP;
      int_state = PHASE_NONE;
      str_left = 64'd0;
      nest_level = 0;
      nest_mem[0] = NS_TOP;
      stream_pos = 32'd0;
   endfunction

   // ':' between key and value, ',' between elements
   function automatic void insert_separator();
      case (nest_mem[nest_level])
         NS_DFIRST: nest_mem[nest_level] = NS_DVAL;
         NS_DVAL: begin
            put_char(CH_COLON);
            nest_mem[nest_level] = NS_DNEXT;
         end
         NS_DNEXT: begin
            put_char(CH_COMMA);
            nest_mem[nest_level] = NS_DVAL;
         end
         NS_LFIRST: nest_mem[nest_level] = NS_LNEXT;
         NS_LNEXT: put_char(CH_COMMA);
         default: ;
      endcase
   endfunction

   function automatic void transcode_word(logic op, byte_type c);
      bit bad;
      nest_type code;
      logic [63:0] digit;
      bad = 1'b0;
      if (err_latched)
         return;
      stream_pos = stream_pos + 32'd1;
      step_words.delete();
      if (op == OP_END) begin
         if (stream_mode != MODE_TOP || nest_level != 0)
            bad = 1'b1;
         else begin
            put_char(CH_LF);
            clear_parser();
         end
      end else begin
         case (stream_mode)
            MODE_INT: begin
               if (is_digit(c)) begin
                  int_state = PHASE_DIGIT;
                  put_char(c);
               end else if (c == CH_E && int_state == PHASE_DIGIT)
                  stream_mode = MODE_TOP;
               else if (c == CH_MINUS && int_state == PHASE_NONE) begin
                  int_state = PHASE_MINUS;
                  put_char(c);
               end else
                  bad = 1'b1;
            end
            MODE_LEN: begin
               if (is_digit(c)) begin
                  digit = 64'(c - CH_ZERO);
                  if (str_left > (LEN_LIMIT - digit) / 64'd10)
                     bad = 1'b1;
                  else
                     str_left = str_left * 64'd10 + digit;
               end else if (c == CH_COLON) begin
                  if (str_left == 64'd0) begin
                     put_char(CH_QUOTE);
                     stream_mode = MODE_TOP;
                  end else
                     stream_mode = MODE_BODY;
               end else
                  bad = 1'b1;
            end
            MODE_BODY: begin
               if (c == CH_QUOTE || c == CH_BSLASH)
                  put_char(CH_BSLASH);
               put_char(c);
               str_left = str_left - 64'd1;
               if (str_left == 64'd0) begin
                  put_char(CH_QUOTE);
                  stream_mode = MODE_TOP;
               end
            end
            default: begin
               if (c == CH_D || c == CH_L) begin
                  if (nest_level + 1 >= NEST_DEPTH)
                     bad = 1'b1;
                  else begin
                     insert_separator();
                     put_char(c == CH_D ? CH_LBRACE : CH_LBRACK);
                     nest_level = nest_level + 1;
                     nest_mem[nest_level] = (c == CH_D) ? NS_DFIRST : NS_LFIRST;
                  end
               end else if (c == CH_I) begin
                  insert_separator();
                  stream_mode = MODE_INT;
                  int_state = PHASE_NONE;
               end else if (is_digit(c)) begin
                  insert_separator();
                  put_char(CH_QUOTE);
                  str_left = 64'(c - CH_ZERO);
                  stream_mode = MODE_LEN;
               end else if (c == CH_E) begin
                  code = nest_mem[nest_level];
                  if (code == NS_LFIRST || code == NS_LNEXT)
                     put_char(CH_RBRACK);
                  else if (code == NS_DFIRST || code == NS_DNEXT)
                     put_char(CH_RBRACE);
                  else
                     bad = 1'b1;
                  if (!bad)
                     nest_level = nest_level - 1;
               end else if (c != CH_LF)
                  bad = 1'b1;
            end
         endcase
      end
      if (bad) begin
         step_words.delete();
         step_words.push_back('{out_byte: 8'd0, byte_valid: 1'b0, parse_error: 1'b1,
                                error_position: stream_pos, last: 1'b0});
         err_latched = 1'b1;
      end
      if (step_words.size() > 0) begin
         step_words[step_words.size() - 1].last = 1'b1;
         foreach (step_words[i])
            expected_json.push_back(step_words[i]);
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("tb: mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // result checking
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen_word = '{rsp_chan.out_byte, rsp_chan.byte_valid, rsp_chan.parse_error,
                       rsp_chan.error_position, rsp_chan.last};
         words_checked++;
         if (expected_json.size() == 0)
            report_mismatch($sformatf("word %h with nothing expected", seen_word));
         else begin
            due_word = expected_json.pop_front();
            if (seen_word.out_byte !== due_word.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h",
                                         seen_word.out_byte, due_word.out_byte));
            if (seen_word.byte_valid !== due_word.byte_valid)
               report_mismatch($sformatf("byte_valid %b, want %b",
                                         seen_word.byte_valid, due_word.byte_valid));
            if (seen_word.parse_error !== due_word.parse_error)
               report_mismatch($sformatf("parse_error %b, want %b",
                                         seen_word.parse_error, due_word.parse_error));
            if (seen_word.error_position !== due_word.error_position)
               report_mismatch($sformatf("error_position %0d, want %0d",
                                         seen_word.error_position, due_word.error_position));
            if (seen_word.last !== due_word.last)
               report_mismatch($sformatf("last %b, want %b",
                                         seen_word.last, due_word.last));
         end
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off = hold_off - 1;
         rsp_chan.ready <= 1'b0;
      end else
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb_bencode_to_json_transcoder: done, errors");
         $finish;
      end
   end

   task automatic send_word(logic op, byte_type b);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.data_byte <= b;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      transcode_word(op, b);
      items_sent++;
   endtask

   task automatic send_bencode();
      foreach (bencode_text[i])
         send_word(OP_DATA, bencode_text[i]);
      bencode_text.delete();
   endtask

   task automatic send_end();
      send_word(OP_END, byte_type'($urandom_range(255)));
      streams_sent++;
   endtask

   task automatic wait_for_json_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_json.size() != 0)
         @(posedge clock);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         bencode_text.push_back(byte_type'(s[i]));
   endfunction

   function automatic byte_type body_byte();
      case ($urandom_range(9))
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_LF;
         default: return byte_type'($urandom_range(255));
      endcase
   endfunction

   function automatic void gen_value(int level);
      int kind;
      int count;
      int len;
      kind = (level >= 3) ? $urandom_range(1) : $urandom_range(3);
      case (kind)
         0: begin
            bencode_text.push_back(CH_I);
            if ($urandom_range(2) == 0)
               bencode_text.push_back(CH_MINUS);
            count = $urandom_range(1, 4);
            repeat (count)
               bencode_text.push_back(byte_type'(CH_ZERO + $urandom_range(9)));
            bencode_text.push_back(CH_E);
         end
         1: begin
            len = ($urandom_range(4) == 0) ? $urandom_range(6, 14) : $urandom_range(5);
            if ($urandom_range(5) == 0)
               bencode_text.push_back(CH_ZERO);
            if (len >= 10)
               bencode_text.push_back(byte_type'(CH_ZERO + len / 10));
            bencode_text.push_back(byte_type'(CH_ZERO + len % 10));
            bencode_text.push_back(CH_COLON);
            repeat (len)
               bencode_text.push_back(body_byte());
         end
         2: begin
            bencode_text.push_back(CH_L);
            count = $urandom_range(level >= 2 ? 2 : 3);
            repeat (count)
               gen_value(level + 1);
            bencode_text.push_back(CH_E);
         end
         default: begin
            bencode_text.push_back(CH_D);
            count = $urandom_range(level >= 2 ? 1 : 2);
            repeat (count) begin
               gen_value(level + 1);
               gen_value(level + 1);
            end
            bencode_text.push_back(CH_E);
         end
      endcase
   endfunction

   function automatic void gen_stream();
      int count;
      count = $urandom_range(1, 3);
      repeat (count) begin
         if ($urandom_range(4) == 0)
            bencode_text.push_back(CH_LF);
         gen_value(0);
      end
   endfunction

   task automatic test_directed();
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      // dict with empty-string and list keys, escapes, raw extremes, top-level newlines
      push_text("d0:i-09ele2:");
      bencode_text.push_back(CH_QUOTE);
      bencode_text.push_back(CH_BSLASH);
      push_text("e");
      bencode_text.push_back(CH_LF);
      push_text("l3:");
      bencode_text.push_back(8'hff);
      bencode_text.push_back(8'h00);
      bencode_text.push_back(CH_LF);
      push_text("ei7e");
      send_bencode();
      send_end();
      wait_for_json_drain();
   endtask

   task automatic test_streams(int idle_pct, int stall_pct, int words);
      int target;
      sender_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = items_sent + words;
      while (items_sent < target) begin
         gen_stream();
         send_bencode();
         send_end();
      end
      wait_for_json_drain();
   endtask

   task automatic test_backpressure();
      int target;
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off = 150;
      target = items_sent + 40;
      while (items_sent < target) begin
         gen_stream();
         send_bencode();
         send_end();
      end
      wait_for_json_drain();
   endtask

   task automatic test_error_latch();
      bad_stream_type kind;
      sender_idle_pct = 9;
      rsp_stall_pct = 9;
      kind = bad_stream_type'($urandom_range(BAD_KINDS - 1));
      case (kind)
         BAD_STRAY_BYTE: begin
            bad_case_text = "stray byte at top level";
            push_text("i5e");
            bencode_text.push_back(CH_COLON);
         end
         BAD_CLOSE_AT_TOP: begin
            bad_case_text = "close with nothing open";
            bencode_text.push_back(CH_E);
         end
         BAD_EMPTY_INT: begin
            bad_case_text = "integer without digits";
            push_text("ie");
         end
         BAD_DOUBLE_MINUS: begin
            bad_case_text = "second minus in integer";
            push_text("i--");
         end
         BAD_LENGTH_BYTE: begin
            bad_case_text = "bad byte in length prefix";
            push_text("3x");
         end
         BAD_LENGTH_OVERFLOW: begin
            bad_case_text = "length above the limit";
            push_text("4294967296");
         end
         BAD_END_IN_BODY: begin
            bad_case_text = "end inside longest allowed string";
            push_text("4294967295:");
         end
         BAD_END_IN_INT: begin
            bad_case_text = "end inside integer";
            push_text("i12");
         end
         BAD_END_IN_LENGTH: begin
            bad_case_text = "end after bare length digit";
            push_text("0");
         end
         BAD_END_OPEN: begin
            bad_case_text = "end with containers open";
            push_text("ld1:a");
         end
         BAD_CLOSE_DICT_VALUE: begin
            bad_case_text = "dict closed while awaiting value";
            push_text("di1ee");
         end
         default: begin
            bad_case_text = "nesting overflow";
            repeat (NEST_DEPTH - 1)
               bencode_text.push_back(CH_L);
            bencode_text.push_back(CH_D);
         end
      endcase
      send_bencode();
      if (kind == BAD_END_IN_BODY || kind == BAD_END_IN_INT || kind == BAD_END_IN_LENGTH
          || kind == BAD_END_OPEN)
         send_word(OP_END, byte_type'($urandom_range(255)));
      // everything after the error is ignored
      repeat (8)
         send_word(logic'($urandom_range(1)), byte_type'($urandom_range(255)));
      wait_for_json_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_DATA;
      req_chan.data_byte = 8'd0;
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off = 0;
      items_sent = 0;
      streams_sent = 0;
      err_latched = 1'b0;
      clear_parser();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_streams(0, 0, 50);
      test_streams(72, 0, 50);
      test_streams(0, 72, 50);
      test_streams(9, 9, 50);
      test_backpressure();
      test_error_latch();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d input words in %0d closed streams, %0d result words checked",
               items_sent, streams_sent, words_checked);
      $display("tb: final error case was %s, later words ignored", bad_case_text);
      if (mismatches == 0 && expected_json.size() == 0)
         $display("tb_bencode_to_json_transcoder: done, clean");
      else
         $display("tb_bencode_to_json_transcoder: done, errors");
      $finish;
   end

endmodule
